// File: src/isc_pkg.sv
// Shared types and constants for the insertion sorter with counts.
// No dependencies; imported by isc_front, isc_back and the top level.
package isc_pkg;

  localparam int VW     = 32;  // element width
  localparam int CW     = 11;  // comparison / swap counter width
  localparam int QDEPTH = 4;   // words in the front queue
  localparam int QAW    = 2;   // front queue pointer width
  localparam int QCW    = 3;   // front queue fill count width

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } isc_state_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
  } isc_item_t;

  typedef struct packed {
    logic      vld;
    isc_item_t item;
  } isc_q_t;

endpackage

// File: src/isc_front.sv
// Front of the sorter: takes input words and queues them with their end-of-set mark.
// Depends on isc_pkg.
module isc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic signed [31:0]      in_value,
  input  logic                    in_last,
  output isc_pkg::isc_q_t         q,
  input  logic                    q_pop
);
  import isc_pkg::*;

  isc_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;
  logic            wr_en, rd_en;

  assign full  = (cnt_r == QCW'(QDEPTH));
  assign wr_en = push && !full;
  assign rd_en = q_pop && (cnt_r != '0);

  assign q.vld  = (cnt_r != '0);
  assign q.item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(wr_en);
    rd_ptr_nxt = rd_ptr_r + QAW'(rd_en);
    cnt_nxt    = cnt_r + QCW'(wr_en) - QCW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= '{value: in_value, last: in_last};
    end
  end

endmodule

// File: src/isc_back.sv
// Back of the sorter: row of insertion cells kept in ascending order, running
// comparison/swap totals, and the drain path into the result register.
// Depends on isc_pkg.
module isc_back #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  isc_pkg::isc_q_t         q,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [31:0]      out_sorted_value,
  output logic                    out_last_out,
  output logic [10:0]             out_compare_count,
  output logic [10:0]             out_swap_count,
  output logic                    out_overflow
);
  import isc_pkg::*;

  localparam int CNTW = $clog2(DEPTH + 1);

  isc_state_t           state_r, state_nxt;
  logic signed [VW-1:0] cell_r [DEPTH];
  logic signed [VW-1:0] cell_nxt [DEPTH];
  logic [CNTW-1:0]      count_r, count_nxt;
  logic [CW-1:0]        cmp_r, cmp_nxt;
  logic [CW-1:0]        swp_r, swp_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic signed [VW-1:0] out_val_r;
  logic                 out_last_r;
  logic [CW-1:0]        out_cmp_r;
  logic [CW-1:0]        out_swp_r;
  logic                 out_ovf_r;

  logic [DEPTH-1:0]     gt;    // cell empty or strictly greater than incoming word
  logic [DEPTH-1:0]     first;
  logic [CNTW-1:0]      pos;   // insertion slot = cells less or equal
  logic [CNTW-1:0]      n_gt;
  logic                 ld_out;

  // Cells stay sorted and filled from slot 0, so gt is a thermometer code.
  always_comb begin
    pos = '0;
    for (int k = 0; k < DEPTH; k++) begin
      gt[k] = (CNTW'(k) >= count_r) || (cell_r[k] > q.item.value);
    end
    for (int k = 0; k < DEPTH; k++) begin
      first[k] = gt[k] && ((k == 0) || !gt[(k == 0) ? 0 : k - 1]);
      if (first[k]) begin
        pos = pos | CNTW'(k);
      end
    end
    n_gt = count_r - pos;
  end

  assign empty             = !out_vld_r;
  assign out_sorted_value  = out_val_r;
  assign out_last_out      = out_last_r;
  assign out_compare_count = out_cmp_r;
  assign out_swap_count    = out_swp_r;
  assign out_overflow      = out_ovf_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    cmp_nxt     = cmp_r;
    swp_nxt     = swp_r;
    ovf_nxt     = ovf_r;
    out_vld_nxt = out_vld_r && !pop;
    q_pop       = 1'b0;
    ld_out      = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      cell_nxt[k] = cell_r[k];
    end

    case (state_r)
      ST_LOAD: begin
        if (q.vld) begin
          q_pop = 1'b1;
          if (count_r < CNTW'(DEPTH)) begin
            for (int k = 0; k < DEPTH; k++) begin
              if (gt[k]) begin
                cell_nxt[k] = (k > 0 && gt[(k == 0) ? 0 : k - 1]) ?
                              cell_r[(k == 0) ? 0 : k - 1] : q.item.value;
              end
            end
            count_nxt = count_r + CNTW'(1);
            swp_nxt   = swp_r + CW'(n_gt);
            cmp_nxt   = cmp_r + CW'(n_gt) + CW'(pos != '0);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q.item.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!out_vld_r || pop) begin
          ld_out      = 1'b1;
          out_vld_nxt = 1'b1;
          for (int k = 0; k < DEPTH - 1; k++) begin
            cell_nxt[k] = cell_r[k + 1];
          end
          count_nxt = count_r - CNTW'(1);
          if (count_r == CNTW'(1)) begin
            state_nxt = ST_LOAD;
            cmp_nxt   = '0;
            swp_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      cmp_r     <= '0;
      swp_r     <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_r     <= cmp_nxt;
      swp_r     <= swp_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      cell_r[k] <= cell_nxt[k];
    end
    if (ld_out) begin
      out_val_r  <= cell_r[0];
      out_last_r <= (count_r == CNTW'(1));
      out_cmp_r  <= cmp_r;
      out_swp_r  <= swp_r;
      out_ovf_r  <= ovf_r;
    end
  end

endmodule

// File: src/insertion_sorter_with_counts_top.sv
// Insertion sorter with counts: each word is inserted into a sorted cell row; a set is read
// out of the result register one word per cycle while pop is high, once the last word is in.
// A word passes the front queue and the cell row before it reaches the result register.
// Throughput: 1 word per cycle on load, 1 result per cycle on drain while pop is high; the cell
// row serves one set at a time, so the front queue (4 words) fills while a set drains.
// Reset (rst_n low, synchronous) empties the queue and result register and clears all counts.
module insertion_sorter_with_counts_top #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  in_value,
  input  logic                in_last,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  out_sorted_value,
  output logic                out_last_out,
  output logic [10:0]         out_compare_count,
  output logic [10:0]         out_swap_count,
  output logic                out_overflow
);
  import isc_pkg::*;

  isc_q_t q;
  logic   q_pop;

  isc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .in_last  (in_last),
    .q        (q),
    .q_pop    (q_pop)
  );

  isc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q                 (q),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_sorted_value  (out_sorted_value),
    .out_last_out      (out_last_out),
    .out_compare_count (out_compare_count),
    .out_swap_count    (out_swap_count),
    .out_overflow      (out_overflow)
  );

endmodule

// File: src/isc_checker.sv
// Port-level checks for the insertion sorter, bound onto the top level.
// Depends on insertion_sorter_with_counts_top port names only.
module isc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] out_sorted_value,
  input logic               out_last_out,
  input logic [10:0]        out_compare_count,
  input logic [10:0]        out_swap_count,
  input logic               out_overflow
);

  // a held result word does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_sorted_value)))
    else $error("result word changed while held");

  // words of one set leave in ascending order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_out) ##1 !empty |->
      (out_sorted_value >= $past(out_sorted_value)))
    else $error("results of a set out of order");

  // totals are the same on every word of a set
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_out) ##1 !empty |->
      (out_compare_count == $past(out_compare_count) &&
       out_swap_count == $past(out_swap_count) &&
       out_overflow == $past(out_overflow)))
    else $error("set totals changed within a set");

  // every swap follows a comparison
  a_swp_le_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_swap_count <= out_compare_count))
    else $error("swap count above comparison count");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("result present after reset");

endmodule

bind insertion_sorter_with_counts_top isc_checker u_isc_checker (.*);

// File: tb/insertion_sorter_with_counts_top_test.sv
// Testbench for insertion_sorter_with_counts_top: a directed table, then random sets,
// with every popped word checked against an in-bench sort model with comparison/swap counts.
// Depends on isc_pkg (widths) and the RTL under src/.
module insertion_sorter_with_counts_top_test;
  import isc_pkg::*;

  localparam int SET_DEPTH  = 64;
  localparam int IDLE_LIMIT = 2000;   // cycles with no word moving on either side
  localparam int HOLD_OFF   = 300;    // one long receiver stall to back up the input
  localparam int RAND_WORDS = 390;
  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
    logic [CW-1:0]        cmp;
    logic [CW-1:0]        swp;
    logic                 ovf;
  } sorted_word_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
    logic                 typed;
    sorted_word_t         want;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic signed [VW-1:0] in_value = '0;
  logic                 in_last = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [VW-1:0] out_sorted_value;
  logic                 out_last_out;
  logic [CW-1:0]        out_compare_count;
  logic [CW-1:0]        out_swap_count;
  logic                 out_overflow;

  insertion_sorter_with_counts_top #(.DEPTH(SET_DEPTH)) uut (
    .clk, .rst_n, .push, .full, .in_value, .in_last,
    .empty, .pop, .out_sorted_value, .out_last_out,
    .out_compare_count, .out_swap_count, .out_overflow
  );

  // set being collected and the words it must produce
  logic signed [VW-1:0] set_buf [SET_DEPTH];
  int                   set_len = 0;
  logic                 set_ovf = 1'b0;
  sorted_word_t         sorted_words [$];
  stim_row_t            directed_rows [$];

  int mismatches = 0;
  int words_popped = 0;
  int idle_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  // stable insertion sort; counts every strict less-than test with j above zero
  function automatic void add_to_set(input logic signed [VW-1:0] v, input logic l);
    int                   i;
    int                   j;
    logic signed [VW-1:0] t;
    logic [CW-1:0]        ncmp;
    logic [CW-1:0]        nswp;
    sorted_word_t         w;
    if (set_len < SET_DEPTH) begin
      set_buf[set_len] = v;
      set_len++;
    end else begin
      set_ovf = 1'b1;
    end
    if (!l) return;
    ncmp = '0;
    nswp = '0;
    for (i = 1; i < set_len; i++) begin
      j = i;
      while (j > 0) begin
        ncmp++;
        if (!(set_buf[j] < set_buf[j-1])) break;
        t = set_buf[j-1];
        set_buf[j-1] = set_buf[j];
        set_buf[j] = t;
        nswp++;
        j--;
      end
    end
    for (i = 0; i < set_len; i++) begin
      w.value = set_buf[i];
      w.last  = (i == set_len - 1);
      w.cmp   = ncmp;
      w.swp   = nswp;
      w.ovf   = set_ovf;
      sorted_words.push_back(w);
    end
    set_len = 0;
    set_ovf = 1'b0;
  endfunction

  function automatic stim_row_t row(input logic signed [VW-1:0] v, input logic l);
    stim_row_t r;
    r = '0;
    r.value = v;
    r.last  = l;
    return r;
  endfunction

  // one-word set with its result written out
  function automatic stim_row_t known(input logic signed [VW-1:0] v,
                                      input logic signed [VW-1:0] exp_value,
                                      input logic [CW-1:0] exp_cmp,
                                      input logic [CW-1:0] exp_swp);
    stim_row_t r;
    r = row(v, 1'b1);
    r.typed      = 1'b1;
    r.want.value = exp_value;
    r.want.last  = 1'b1;
    r.want.cmp   = exp_cmp;
    r.want.swp   = exp_swp;
    r.want.ovf   = 1'b0;
    return r;
  endfunction

  function automatic logic signed [VW-1:0] pick_value(input int mode);
    logic signed [VW-1:0] v;
    case (mode)
      1: v = $signed($urandom_range(0, 8)) - 4;   // many ties
      2: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = VAL_MIN + 1;
          3: v = VAL_MAX - 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic offer(input logic signed [VW-1:0] v, input logic l, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // sender
  initial begin
    int                   n;
    int                   k;
    int                   mode;
    int                   gap;
    int                   sent;
    int                   base;
    int                   step;
    bit                   calm;
    logic signed [VW-1:0] v;
    logic                 l;

    directed_rows.push_back(known(VAL_MIN, VAL_MIN, '0, '0));
    directed_rows.push_back(known(VAL_MAX, VAL_MAX, '0, '0));
    directed_rows.push_back(known(0, 0, '0, '0));
    directed_rows.push_back(known(-1, -1, '0, '0));
    // fully reversed
    directed_rows.push_back(row(VAL_MAX, 1'b0));
    directed_rows.push_back(row(0, 1'b0));
    directed_rows.push_back(row(VAL_MIN, 1'b1));
    // already ascending
    directed_rows.push_back(row(VAL_MIN, 1'b0));
    directed_rows.push_back(row(-1, 1'b0));
    directed_rows.push_back(row(1, 1'b0));
    directed_rows.push_back(row(VAL_MAX, 1'b1));
    // ties
    directed_rows.push_back(row(7, 1'b0));
    directed_rows.push_back(row(-7, 1'b0));
    directed_rows.push_back(row(7, 1'b0));
    directed_rows.push_back(row(-7, 1'b1));
    directed_rows.push_back(row(32'sh5555_5555, 1'b0));
    directed_rows.push_back(row(32'shaaaa_aaaa, 1'b1));
    directed_rows.push_back(row(0, 1'b0));
    directed_rows.push_back(row(0, 1'b1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      offer(directed_rows[r].value, directed_rows[r].last, gap);
      add_to_set(directed_rows[r].value, directed_rows[r].last);
      if (directed_rows[r].typed) begin
        void'(sorted_words.pop_back());
        sorted_words.push_back(directed_rows[r].want);
      end
    end

    sent = 0;
    for (int s = 0; sent < RAND_WORDS; s++) begin
      if (s == 0) n = SET_DEPTH;           // strictly descending: most comparisons and swaps
      else if (s == 1) n = SET_DEPTH + 1;  // word marked last is dropped
      else if ($urandom_range(0, 11) == 0) n = $urandom_range(SET_DEPTH - 4, SET_DEPTH + 6);
      else n = $urandom_range(1, 10);
      mode = $urandom_range(0, 3);
      calm = ($urandom_range(0, 3) == 0);
      base = $urandom_range(0, 1000000);
      step = $urandom_range(1, 1000);
      for (k = 0; k < n; k++) begin
        v = (s == 0) ? base - k * step : pick_value(mode);
        l = (k == n - 1);
        gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        offer(v, l, gap);
        add_to_set(v, l);
        sent++;
      end
    end
    push <= 1'b0;

    while (sorted_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // receiver: checks each popped word, stalls at random
  initial begin
    int           stall_left;
    int           calm_left;
    bit           held_once;
    logic         next_pop;
    sorted_word_t want;
    stall_left = 0;
    calm_left  = 0;
    held_once  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        words_popped++;
        if (sorted_words.size() == 0) begin
          $error("unexpected word: sorted_value %0d", out_sorted_value);
          mismatches++;
        end else begin
          want = sorted_words.pop_front();
          if (out_sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", want.value, out_sorted_value);
            mismatches++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, out_last_out);
            mismatches++;
          end
          if (out_compare_count !== want.cmp) begin
            $error("compare_count: expected %0d, got %0d", want.cmp, out_compare_count);
            mismatches++;
          end
          if (out_swap_count !== want.swp) begin
            $error("swap_count: expected %0d, got %0d", want.swp, out_swap_count);
            mismatches++;
          end
          if (out_overflow !== want.ovf) begin
            $error("overflow: expected %0d, got %0d", want.ovf, out_overflow);
            mismatches++;
          end
        end
      end
      // long hold once, so the front queue fills and full rises
      if (!held_once && words_popped >= 30) begin
        held_once  = 1'b1;
        stall_left = HOLD_OFF;
      end
      if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end else begin
        next_pop = 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        else if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 80);
      end
      pop <= next_pop;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule
